FILE: rtl/core/rhc_pkg.sv
// Shared types and constants for the RGB to HSV converter.
package rhc_pkg;

    // Width of the hue result field
    localparam int HUE_BITS = 13;

    // Degrees per hue sector and per full turn
    localparam int DEG_SECTOR = 60;
    localparam int DEG_TURN   = 360;

    // Which channel holds the maximum; gray means all channels equal
    typedef enum logic [1:0] {
        SECT_GRAY  = 2'd0,
        SECT_RED   = 2'd1,
        SECT_GREEN = 2'd2,
        SECT_BLUE  = 2'd3
    } sector_t;

    // Hue control that travels alongside the hue division
    typedef struct packed {
        sector_t sector;
        logic    neg;     // numerator difference is negative
    } hue_ctl_t;

endpackage

FILE: rtl/core/rhc_front.sv
// Front stages: max/min, sector select, then numerator products for both divisions.
module rhc_front #(
    parameter int CB = 8,
    parameter int HF = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              pipe_en,
    input  logic                              in_valid,
    input  logic [CB-1:0]                     red,
    input  logic [CB-1:0]                     green,
    input  logic [CB-1:0]                     blue,
    output logic                              out_valid,
    output rhc_pkg::hue_ctl_t                 out_ctl,
    output logic [CB-1:0]                     out_max,
    output logic [CB-1:0]                     out_spread,
    output logic [CB+$clog2((rhc_pkg::DEG_SECTOR << HF) + 1)-1:0] out_hue_num,
    output logic [2*CB-1:0]                   out_sat_num
);

    localparam int SECTOR_UNITS = rhc_pkg::DEG_SECTOR << HF;
    localparam int SU_W         = $clog2(SECTOR_UNITS + 1);
    localparam int NUM_W        = CB + SU_W;

    // Stage 1 combinational
    logic [CB-1:0]       mx_c;
    logic [CB-1:0]       mn_c;
    logic [CB-1:0]       x_c;
    logic [CB-1:0]       y_c;
    rhc_pkg::sector_t    sect_c;

    // Stage 1 registers
    logic                v1_reg;
    logic                v1_next;
    rhc_pkg::hue_ctl_t   ctl1_reg;
    rhc_pkg::hue_ctl_t   ctl1_next;
    logic [CB-1:0]       mx1_reg;
    logic [CB-1:0]       mx1_next;
    logic [CB-1:0]       d1_reg;
    logic [CB-1:0]       d1_next;
    logic [CB-1:0]       a1_reg;
    logic [CB-1:0]       a1_next;

    // Stage 2 registers
    logic                v2_reg;
    logic                v2_next;
    rhc_pkg::hue_ctl_t   ctl2_reg;
    logic [CB-1:0]       mx2_reg;
    logic [CB-1:0]       d2_reg;
    logic [NUM_W-1:0]    hnum2_reg;
    logic [NUM_W-1:0]    hnum2_next;
    logic [2*CB-1:0]     snum2_reg;
    logic [2*CB-1:0]     snum2_next;

    // Largest and smallest channel, ties resolved red, green, blue
    always_comb begin
        mx_c = red;
        if (green > mx_c) mx_c = green;
        if (blue > mx_c) mx_c = blue;
        mn_c = red;
        if (green < mn_c) mn_c = green;
        if (blue < mn_c) mn_c = blue;

        sect_c = rhc_pkg::SECT_RED;
        x_c    = green;
        y_c    = blue;
        if (mx_c == mn_c) begin
            sect_c = rhc_pkg::SECT_GRAY;
        end else if (red == mx_c) begin
            sect_c = rhc_pkg::SECT_RED;
        end else if (green == mx_c) begin
            sect_c = rhc_pkg::SECT_GREEN;
            x_c    = blue;
            y_c    = red;
        end else begin
            sect_c = rhc_pkg::SECT_BLUE;
            x_c    = red;
            y_c    = green;
        end
    end

    // Stage 1 next values: spread and magnitude of the sector numerator
    always_comb begin
        v1_next          = in_valid;
        ctl1_next.sector = sect_c;
        ctl1_next.neg    = (x_c < y_c);
        a1_next          = (x_c < y_c) ? (y_c - x_c) : (x_c - y_c);
        d1_next          = mx_c - mn_c;
        mx1_next         = mx_c;
    end

    // Stage 2 next values: scale by sector units, and d * full scale
    always_comb begin
        v2_next    = v1_reg;
        hnum2_next = NUM_W'(a1_reg) * NUM_W'(SECTOR_UNITS);
        snum2_next = {d1_reg, {CB{1'b0}}} - (2*CB)'(d1_reg);
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (pipe_en) begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ctl1_reg  <= ctl1_next;
            mx1_reg   <= mx1_next;
            d1_reg    <= d1_next;
            a1_reg    <= a1_next;
            ctl2_reg  <= ctl1_reg;
            mx2_reg   <= mx1_reg;
            d2_reg    <= d1_reg;
            hnum2_reg <= hnum2_next;
            snum2_reg <= snum2_next;
        end
    end

    assign out_valid   = v2_reg;
    assign out_ctl     = ctl2_reg;
    assign out_max     = mx2_reg;
    assign out_spread  = d2_reg;
    assign out_hue_num = hnum2_reg;
    assign out_sat_num = snum2_reg;

endmodule

FILE: rtl/core/rhc_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
module rhc_div #(
    parameter int NW     = 16,
    parameter int DW     = 8,
    parameter int QW     = 8,
    parameter int SIDE_W = 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              pipe_en,
    input  logic              in_valid,
    input  logic [NW-1:0]     num,
    input  logic [DW-1:0]     den,
    input  logic [SIDE_W-1:0] side,
    output logic              out_valid,
    output logic [QW-1:0]     quo,
    output logic              rem_nz,
    output logic [SIDE_W-1:0] side_out
);

    localparam int EW = QW + DW;

    // Dividend widened so the top DW bits start below the divisor
    logic [EW-1:0] ext;

    // Per-stage inputs
    logic [DW-1:0]     rem_in  [QW];
    logic [QW-1:0]     lq_in   [QW];
    logic [DW-1:0]     den_in  [QW];
    logic [SIDE_W-1:0] side_in [QW];
    logic              v_in    [QW];

    // Per-stage registers
    logic [DW-1:0]     rem_reg  [QW];
    logic [DW-1:0]     rem_next [QW];
    logic [QW-1:0]     lq_reg   [QW];
    logic [QW-1:0]     lq_next  [QW];
    logic [DW-1:0]     den_reg  [QW];
    logic [SIDE_W-1:0] side_reg [QW];
    logic              v_reg    [QW];

    assign ext = EW'(num);

    genvar k;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            logic [DW:0] trial;
            logic [DW:0] diff;
            logic        ge;

            // Stage input: ports for the first stage, previous stage otherwise
            if (k == 0) begin : g_first
                assign rem_in[k]  = ext[EW-1:QW];
                assign lq_in[k]   = ext[QW-1:0];
                assign den_in[k]  = den;
                assign side_in[k] = side;
                assign v_in[k]    = in_valid;
            end else begin : g_next
                assign rem_in[k]  = rem_reg[k-1];
                assign lq_in[k]   = lq_reg[k-1];
                assign den_in[k]  = den_reg[k-1];
                assign side_in[k] = side_reg[k-1];
                assign v_in[k]    = v_reg[k-1];
            end

            // Shift in the next dividend bit, subtract if it fits
            assign trial       = {rem_in[k], lq_in[k][QW-1]};
            assign diff        = trial - (DW+1)'(den_in[k]);
            assign ge          = (trial >= (DW+1)'(den_in[k]));
            assign rem_next[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
            assign lq_next[k]  = {lq_in[k][QW-2:0], ge};

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    v_reg[k] <= 1'b0;
                end else if (pipe_en) begin
                    v_reg[k] <= v_in[k];
                end
            end

            always_ff @(posedge aclk) begin
                if (pipe_en) begin
                    rem_reg[k]  <= rem_next[k];
                    lq_reg[k]   <= lq_next[k];
                    den_reg[k]  <= den_in[k];
                    side_reg[k] <= side_in[k];
                end
            end
        end
    endgenerate

    assign out_valid = v_reg[QW-1];
    assign quo       = lq_reg[QW-1];
    assign rem_nz    = |rem_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

FILE: rtl/core/rhc_back.sv
// Final stage: sector offset and wrap for hue, saturation clamp, output register.
module rhc_back #(
    parameter int CB = 8,
    parameter int HF = 4,
    parameter int QW = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          pipe_en,
    input  logic                          in_valid,
    input  rhc_pkg::hue_ctl_t             ctl,
    input  logic [QW-1:0]                 hue_q,
    input  logic                          hue_rem_nz,
    input  logic [QW-1:0]                 sat_q,
    input  logic [CB-1:0]                 max_val,
    output logic                          out_valid,
    output logic [rhc_pkg::HUE_BITS-1:0]  hue,
    output logic [CB-1:0]                 saturation,
    output logic [CB-1:0]                 brightness
);

    localparam int SECTOR_UNITS = rhc_pkg::DEG_SECTOR << HF;
    localparam int TURN_UNITS   = rhc_pkg::DEG_TURN << HF;
    localparam int HW           = $clog2(TURN_UNITS + 1);
    localparam int HX           = (HW > rhc_pkg::HUE_BITS) ? HW : rhc_pkg::HUE_BITS;

    logic [HX-1:0]                 q_ext;
    logic [HX-1:0]                 q_ceil;
    logic [HX-1:0]                 base;
    logic [HX-1:0]                 h_full;

    logic                          v_reg;
    logic                          v_next;
    logic [rhc_pkg::HUE_BITS-1:0]  hue_reg;
    logic [rhc_pkg::HUE_BITS-1:0]  hue_next;
    logic [CB-1:0]                 sat_reg;
    logic [CB-1:0]                 sat_next;
    logic [CB-1:0]                 bri_reg;

    // Floor of a negative fraction is minus the ceiling of its magnitude
    assign q_ext  = HX'(hue_q);
    assign q_ceil = q_ext + HX'(hue_rem_nz);

    // Sector offset; a negative red-sector hue wraps by a full turn
    always_comb begin
        case (ctl.sector)
            rhc_pkg::SECT_RED:   base = ctl.neg ? HX'(TURN_UNITS) : '0;
            rhc_pkg::SECT_GREEN: base = HX'(2 * SECTOR_UNITS);
            rhc_pkg::SECT_BLUE:  base = HX'(4 * SECTOR_UNITS);
            default:             base = '0;
        endcase
    end

    always_comb begin
        if (ctl.sector == rhc_pkg::SECT_GRAY) begin
            h_full = '0;
        end else if (ctl.neg) begin
            h_full = base - q_ceil;
        end else begin
            h_full = base + q_ext;
        end
    end

    // Next values of the output register
    always_comb begin
        v_next   = in_valid;
        hue_next = h_full[rhc_pkg::HUE_BITS-1:0];
        sat_next = (max_val == '0) ? '0 : sat_q[CB-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (pipe_en) begin
            v_reg <= v_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            hue_reg <= hue_next;
            sat_reg <= sat_next;
            bri_reg <= max_val;
        end
    end

    assign out_valid  = v_reg;
    assign hue        = hue_reg;
    assign saturation = sat_reg;
    assign brightness = bri_reg;

endmodule

FILE: rtl/core/rgb_to_hsv_convert.sv
// RGB to HSV converter, top level with stream ports.
//
// Converts one RGB pixel to HSV each clock cycle while the pipeline is not held.
// Hue is in 1/2^HUE_FRAC_BITS degree units (0..5759 at the defaults, floored),
// saturation is floor((max-min)*full/max) and brightness is the largest channel.
// The pipeline is 2 + Q + 1 register stages deep, where Q = max(CHANNEL_BITS,
// clog2(60*2^HUE_FRAC_BITS + 1)) is the number of stages of the bit-per-stage
// dividers. A new pixel can be taken every cycle; the whole pipeline holds while
// the output register waits on m_tready, and s_tready is high whenever the
// output register is empty or being drained.
module rgb_to_hsv_convert #(
    parameter int CHANNEL_BITS  = 8,
    parameter int HUE_FRAC_BITS = 4
) (
    input  logic aclk,
    input  logic aresetn,

    input  logic s_tvalid,
    output logic s_tready,
    // red, green, blue (CHANNEL_BITS each), from bit 0 up
    input  logic [((3*CHANNEL_BITS+7)/8)*8-1:0] s_tdata,

    output logic m_tvalid,
    input  logic m_tready,
    // hue (13), saturation (CHANNEL_BITS), brightness (CHANNEL_BITS), from bit 0 up
    output logic [((rhc_pkg::HUE_BITS+2*CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);

    localparam int CB       = CHANNEL_BITS;
    localparam int SU_W     = $clog2((rhc_pkg::DEG_SECTOR << HUE_FRAC_BITS) + 1);
    localparam int QW       = (SU_W > CB) ? SU_W : CB;
    localparam int M_W      = ((rhc_pkg::HUE_BITS + 2*CB + 7) / 8) * 8;
    localparam int CTL_W    = $bits(rhc_pkg::hue_ctl_t);

    logic                         pipe_en;

    // Front outputs
    logic                         f_valid;
    rhc_pkg::hue_ctl_t            f_ctl;
    logic [CB-1:0]                f_max;
    logic [CB-1:0]                f_spread;
    logic [CB+SU_W-1:0]           f_hue_num;
    logic [2*CB-1:0]              f_sat_num;

    // Divider outputs
    logic                         hd_valid;
    logic [QW-1:0]                hd_quo;
    logic                         hd_rem_nz;
    logic [CTL_W-1:0]             hd_side;
    rhc_pkg::hue_ctl_t            hd_ctl;
    logic                         sd_valid;
    logic [QW-1:0]                sd_quo;
    logic [CB-1:0]                sd_max;

    // Result fields
    logic                         out_valid;
    logic [rhc_pkg::HUE_BITS-1:0] hue;
    logic [CB-1:0]                saturation;
    logic [CB-1:0]                brightness;

    // Pipeline advances unless a result is held in the output register
    assign pipe_en  = !out_valid || m_tready;
    assign s_tready = pipe_en;

    rhc_front #(
        .CB (CB),
        .HF (HUE_FRAC_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pipe_en     (pipe_en),
        .in_valid    (s_tvalid),
        .red         (s_tdata[CB-1:0]),
        .green       (s_tdata[2*CB-1:CB]),
        .blue        (s_tdata[3*CB-1:2*CB]),
        .out_valid   (f_valid),
        .out_ctl     (f_ctl),
        .out_max     (f_max),
        .out_spread  (f_spread),
        .out_hue_num (f_hue_num),
        .out_sat_num (f_sat_num)
    );

    // Hue fraction: scaled numerator over spread
    rhc_div #(
        .NW     (CB + SU_W),
        .DW     (CB),
        .QW     (QW),
        .SIDE_W (CTL_W)
    ) u_hue_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (f_valid),
        .num       (f_hue_num),
        .den       (f_spread),
        .side      (f_ctl),
        .out_valid (hd_valid),
        .quo       (hd_quo),
        .rem_nz    (hd_rem_nz),
        .side_out  (hd_side)
    );

    // Saturation: spread times full scale over maximum
    rhc_div #(
        .NW     (2 * CB),
        .DW     (CB),
        .QW     (QW),
        .SIDE_W (CB)
    ) u_sat_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pipe_en   (pipe_en),
        .in_valid  (f_valid),
        .num       (f_sat_num),
        .den       (f_max),
        .side      (f_max),
        .out_valid (sd_valid),
        .quo       (sd_quo),
        .rem_nz    (),
        .side_out  (sd_max)
    );

    assign hd_ctl = rhc_pkg::hue_ctl_t'(hd_side);

    rhc_back #(
        .CB (CB),
        .HF (HUE_FRAC_BITS),
        .QW (QW)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .pipe_en    (pipe_en),
        .in_valid   (hd_valid & sd_valid),
        .ctl        (hd_ctl),
        .hue_q      (hd_quo),
        .hue_rem_nz (hd_rem_nz),
        .sat_q      (sd_quo),
        .max_val    (sd_max),
        .out_valid  (out_valid),
        .hue        (hue),
        .saturation (saturation),
        .brightness (brightness)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = M_W'({brightness, saturation, hue});

endmodule
